// ===== rtl/sssp_pkg.sv =====
// Package for the shortest-path unit: operation codes and controller state type.
// Used by sssp_ctrl, sssp_dp and the top level.
package sssp_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int DIST_BITS = 20;

  typedef enum logic [3:0] {
    ST_WIPE,     // clearing pass over the edge memory
    ST_IDLE,
    ST_ADD_RD,   // read old weight of a->b
    ST_ADD_WA,   // write a->b, read b->a
    ST_ADD_WB,   // write b->a
    ST_INIT,     // reset per-node flags
    ST_SCAN,     // linear minimum search, one node per cycle
    ST_RELAX,    // read edges of settled node, one per cycle
    ST_EMIT      // send one result per node
  } state_t;

  typedef struct packed {
    logic wipe;
    logic add_rd;
    logic add_wa;
    logic add_wb;
    logic init;
    logic scan;
    logic scan_done;
    logic relax;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic found;
    logic start_ok;
  } sts_t;

endpackage

// ===== rtl/sssp_ctrl.sv =====
// Controller state machine of the shortest-path unit.
// Depends on sssp_pkg for the state and command types.
module sssp_ctrl import sssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_go,
  input  logic [1:0] op,
  input  logic       out_take,
  input  logic       out_last,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       in_ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_WIPE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_WIPE:   if (sts.cnt_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_go) begin
          case (op)
            OP_CLEAR: state_next = ST_WIPE;
            OP_ADD:   state_next = ST_ADD_RD;
            OP_QUERY: state_next = ST_INIT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: state_next = ST_ADD_WA;
      ST_ADD_WA: state_next = ST_ADD_WB;
      ST_ADD_WB: state_next = ST_IDLE;
      ST_INIT:   state_next = sts.start_ok ? ST_SCAN : ST_EMIT;
      ST_SCAN: begin
        if (sts.cnt_last) state_next = ST_RELAX;
      end
      ST_RELAX: begin
        // A scan with no candidate ends the search.
        if (!sts.found) state_next = ST_EMIT;
        else if (sts.cnt_last) state_next = ST_SCAN;
      end
      ST_EMIT:   if (out_take && out_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_WIPE:   cmd.wipe = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_ADD_RD: cmd.add_rd = 1'b1;
      ST_ADD_WA: cmd.add_wa = 1'b1;
      ST_ADD_WB: cmd.add_wb = 1'b1;
      ST_INIT:   cmd.init = 1'b1;
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cmd.scan_done = sts.cnt_last;
      end
      ST_RELAX:  cmd.relax = sts.found;
      ST_EMIT:   cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/sssp_dp.sv =====
// Datapath of the shortest-path unit: edge memory, distance table, scan and relax.
// Depends on sssp_pkg; driven by sssp_ctrl commands.
module sssp_dp import sssp_pkg::*; #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   in_go,
  input  logic [3:0]             node_a,
  input  logic [3:0]             node_b,
  input  logic [15:0]            weight,
  input  logic [3:0]             start_node,
  input  logic                   out_stall,
  output logic                   out_take,
  output logic                   valid_o,
  output logic [3:0]             node,
  output logic [DIST_BITS-1:0]   distance,
  output logic                   reachable,
  output logic                   last
);

  localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AB = 2 * NB;
  localparam int EW = WEIGHT_BITS + 1;        // present bit on top
  localparam int FB = WEIGHT_BITS + 8;        // full-width distance
  localparam int DW = (FB > DIST_BITS) ? FB : DIST_BITS;

  // Edge memory: one read port with registered data, one write port.
  logic [EW-1:0] emem [NODES*NODES];
  logic [EW-1:0] rd_data;
  logic [AB-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) emem[wr_addr] <= wr_data;
    rd_data <= emem[rd_addr];
  end

  logic [NB:0]   cnt;          // node counter, one wider to hold NODES
  logic [AB:0]   wcnt;         // wipe counter
  logic [NB-1:0] ea, eb, u;
  logic [WEIGHT_BITS-1:0] w;
  logic          add_ok;
  logic [3:0]    sn;           // start node of the query being worked on
  logic [DW-1:0] best [NODES];
  logic [NODES-1:0] settled, known;
  logic          found;
  logic [DW-1:0] min_d, du;
  logic [NB-1:0] min_i;
  logic          rv;           // relax read valid
  logic [NB-1:0] rv_i;

  wire cnt_end = (cnt == (NB+1)'(NODES - 1));
  wire [NB-1:0] ci = cnt[NB-1:0];

  assign sts.cnt_last = cmd.wipe ? (wcnt == (AB+1)'(NODES*NODES - 1)) : cnt_end;
  assign sts.found    = found;
  assign sts.start_ok = ({1'b0, sn} < 5'(NODES));

  // Memory addressing.
  always_comb begin
    rd_addr = {ea, eb};
    wr_en   = 1'b0;
    wr_addr = {ea, eb};
    wr_data = {1'b1, w};
    if (cmd.wipe) begin
      wr_en   = 1'b1;
      wr_addr = wcnt[AB-1:0];
      wr_data = '0;
    end else if (cmd.add_wa) begin
      rd_addr = {eb, ea};
      wr_en   = add_ok && (!rd_data[EW-1] || w < rd_data[WEIGHT_BITS-1:0]);
    end else if (cmd.add_wb) begin
      wr_addr = {eb, ea};
      wr_en   = add_ok && (!rd_data[EW-1] || w < rd_data[WEIGHT_BITS-1:0]);
    end else if (cmd.relax) begin
      rd_addr = {u, ci};
    end
  end

  wire [DW-1:0] cand = du + DW'(rd_data[WEIGHT_BITS-1:0]);
  wire [NB:0] start_w = (NB+1)'(sn);

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
      cnt <= '0;
      settled <= '0;
      known <= '0;
      found <= 1'b0;
      rv <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      rv <= 1'b0;
      if (cmd.wipe) wcnt <= sts.cnt_last ? '0 : wcnt + 1'b1;
      if (in_go) begin
        ea <= node_a[NB-1:0];
        eb <= node_b[NB-1:0];
        w  <= WEIGHT_BITS'(weight);
        sn <= start_node;
        add_ok <= ({1'b0, node_a} < 5'(NODES)) && ({1'b0, node_b} < 5'(NODES));
      end
      if (cmd.init) begin
        settled <= '0;
        known <= '0;
        cnt <= '0;
        found <= 1'b0;
        if (sts.start_ok) begin
          known[start_w[NB-1:0]] <= 1'b1;
          best[start_w[NB-1:0]] <= '0;
        end
      end
      if (cmd.scan) begin
        if (known[ci] && !settled[ci] && (!found || best[ci] < min_d)) begin
          found <= 1'b1;
          min_d <= best[ci];
          min_i <= ci;
        end
        cnt <= cnt_end ? '0 : cnt + 1'b1;
      end
      if (cmd.scan_done) begin
        // Settle the winner when the last node is compared in this cycle.
        if (known[ci] && !settled[ci] && (!found || best[ci] < min_d)) begin
          u <= ci; du <= best[ci]; settled[ci] <= 1'b1; found <= 1'b1;
        end else if (found) begin
          u <= min_i; du <= min_d; settled[min_i] <= 1'b1;
        end
      end
      if (cmd.relax) begin
        rv <= 1'b1;
        rv_i <= ci;
        cnt <= cnt_end ? '0 : cnt + 1'b1;
        if (cnt_end) found <= 1'b0;
      end
      if (rv && rd_data[EW-1]) begin
        if (!known[rv_i] || cand < best[rv_i]) begin
          best[rv_i] <= cand;
          known[rv_i] <= 1'b1;
        end
      end
      // Result register; drains the last relax write before the first result.
      if (cmd.emit && !rv && (!valid_o || !out_stall)) begin
        if (valid_o && last) begin
          valid_o <= 1'b0;
        end else begin
          valid_o <= 1'b1;
          node <= 4'(cnt);
          distance <= known[ci] ? best[ci][DIST_BITS-1:0] : '0;
          reachable <= known[ci];
          last <= cnt_end;
          cnt <= cnt_end ? '0 : cnt + 1'b1;
        end
      end else if (valid_o && !out_stall && last) begin
        valid_o <= 1'b0;
      end
    end
  end

  assign out_take = valid_o && !out_stall;

`ifndef ASSERT_OFF
  a_no_dbl_settle: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_done && found |=> $countones(settled) == $countones($past(settled)) + 1)
    else $error("settle count mismatch");
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(valid_o) |-> $past(cmd.emit))
    else $error("result outside emit");
  a_wipe_no_take: assert property (@(posedge clk) disable iff (rst)
    cmd.wipe |-> !in_go)
    else $error("item taken during wipe");
`endif

endmodule

// ===== rtl/single_source_shortest_path_unit.sv =====
// Top level of the shortest-path unit: controller plus datapath.
// Depends on sssp_pkg, sssp_ctrl and sssp_dp.
//
// The input channel (in_valid / in_stall) takes one item: clear, add edge
// or query. Operation 3 and adds with an endpoint at or above NODES are
// taken and dropped. A clear wipes all NODES*NODES entries of the edge
// memory; an add writes a->b and b->a when the edge is new or lighter.
// A query runs Dijkstra with a linear minimum scan: each round scans all
// nodes and then reads the edges of the settled node through the single
// memory read port, for up to NODES rounds. It then sends NODES
// result items on the output channel (out_valid / out_stall), one per node
// in index order, the final one flagged by last. An unreachable node
// reports distance 0.
// One item is worked on at a time; in_stall is high while busy.
// After reset all NODES*NODES entries of the edge memory are wiped and no
// item is taken meanwhile. When the receiver stalls, the current result
// holds steady and the next result waits.
module single_source_shortest_path_unit import sssp_pkg::*; #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [3:0]           node_a,
  input  logic [3:0]           node_b,
  input  logic [15:0]          weight,
  input  logic [3:0]           start_node,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           node,
  output logic [DIST_BITS-1:0] distance,
  output logic                 reachable,
  output logic                 last
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready, in_go, out_take;

  assign in_stall = !in_ready;
  assign in_go    = in_valid && in_ready;

  sssp_ctrl u_ctrl (
    .clk, .rst, .in_go, .op(operation), .out_take, .out_last(last),
    .sts, .cmd, .in_ready
  );

  sssp_dp #(.NODES(NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .in_go, .node_a, .node_b, .weight, .start_node,
    .out_stall, .out_take, .valid_o(out_valid), .node, .distance, .reachable,
    .last
  );

endmodule
